[design/mtst_pkg.sv]
// ----------------------------------------------------------------------------
// mtst_pkg: shared types and constants of the markup tag stream tokenizer
// Result word layout, record kinds, node types, character codes, builders.
// ----------------------------------------------------------------------------
`default_nettype none

package mtst_pkg;

  localparam int KIND_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int NTYPE_W  = 3;
  localparam int COLOR_W  = 24;
  localparam int FSIZE_W  = 6;
  localparam int TLEN_W   = 7;
  localparam int NIDX_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam int TITLE_MAX = 127;
  localparam int PFX_LEN   = 5;
  localparam int HREF_LEN  = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_COLOR = 1'd1;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 24'hCDD6F4;
  localparam logic [COLOR_W-1:0] LINK_COLOR_RST = 24'h89B4FA;

  // record kinds
  localparam logic [KIND_W-1:0] K_HREF_START  = 3'd0;
  localparam logic [KIND_W-1:0] K_HREF_BYTE   = 3'd1;
  localparam logic [KIND_W-1:0] K_NODE_START  = 3'd2;
  localparam logic [KIND_W-1:0] K_TEXT_BYTE   = 3'd3;
  localparam logic [KIND_W-1:0] K_NODE_END    = 3'd4;
  localparam logic [KIND_W-1:0] K_TITLE_START = 3'd5;
  localparam logic [KIND_W-1:0] K_TITLE_BYTE  = 3'd6;

  // node types
  localparam logic [NTYPE_W-1:0] NT_TEXT   = 3'd0;
  localparam logic [NTYPE_W-1:0] NT_H1     = 3'd1;
  localparam logic [NTYPE_W-1:0] NT_H2     = 3'd2;
  localparam logic [NTYPE_W-1:0] NT_H3     = 3'd3;
  localparam logic [NTYPE_W-1:0] NT_PARA   = 3'd4;
  localparam logic [NTYPE_W-1:0] NT_ANCHOR = 3'd5;
  localparam logic [NTYPE_W-1:0] NT_BREAK  = 3'd6;

  localparam logic [FSIZE_W-1:0] FS_H1   = 6'd32;
  localparam logic [FSIZE_W-1:0] FS_H2   = 6'd24;
  localparam logic [FSIZE_W-1:0] FS_H3   = 6'd20;
  localparam logic [FSIZE_W-1:0] FS_BODY = 6'd16;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  value;
    logic [NTYPE_W-1:0] node_type;
    logic [COLOR_W-1:0] color;
    logic [FSIZE_W-1:0] font_size;
    logic               bold;
    logic               keep_href;
    logic [TLEN_W-1:0]  text_length;
    logic [NIDX_W-1:0]  node_index;
    logic               last;
  } rec_t;

  // byte of the href=" pattern at a match position
  function automatic logic [7:0] href_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_H;
      3'd1:    c = CH_R;
      3'd2:    c = CH_E;
      3'd3:    c = CH_F;
      3'd4:    c = CH_EQ;
      3'd5:    c = CH_QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic rec_t mk_kind(input logic [KIND_W-1:0] k);
    rec_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic rec_t mk_byte(input logic [KIND_W-1:0] k, input logic [7:0] b);
    rec_t r;
    r       = '0;
    r.kind  = k;
    r.value = b;
    return r;
  endfunction

  function automatic rec_t mk_start(input logic [NTYPE_W-1:0] nt,
                                    input logic [COLOR_W-1:0] col,
                                    input logic [FSIZE_W-1:0] fs,
                                    input logic               bld,
                                    input logic               keep,
                                    input logic [NIDX_W-1:0]  idx);
    rec_t r;
    r            = '0;
    r.kind       = K_NODE_START;
    r.node_type  = nt;
    r.color      = col;
    r.font_size  = fs;
    r.bold       = bld;
    r.keep_href  = keep;
    r.node_index = idx;
    return r;
  endfunction

  function automatic rec_t mk_end(input logic [TLEN_W-1:0] len, input logic [NIDX_W-1:0] idx);
    rec_t r;
    r             = '0;
    r.kind        = K_NODE_END;
    r.text_length = len;
    r.node_index  = idx;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/mtst_if.sv]
// ----------------------------------------------------------------------------
// mtst_if: channel interfaces of the markup tag stream tokenizer
// Document byte channel, result record channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_doc;

  modport source (output valid, output in_byte, output end_of_doc, input ready);
  modport sink   (input valid, input in_byte, input end_of_doc, output ready);
endinterface

interface mtst_out_if;
  logic                              valid;
  logic                              ready;
  logic [mtst_pkg::KIND_W-1:0]       kind;
  logic [mtst_pkg::BYTE_W-1:0]       value;
  logic [mtst_pkg::NTYPE_W-1:0]      node_type;
  logic [mtst_pkg::COLOR_W-1:0]      color;
  logic [mtst_pkg::FSIZE_W-1:0]      font_size;
  logic                              bold;
  logic                              keep_href;
  logic [mtst_pkg::TLEN_W-1:0]       text_length;
  logic [mtst_pkg::NIDX_W-1:0]       node_index;
  logic                              last;

  modport source (output valid, output kind, output value, output node_type, output color,
                  output font_size, output bold, output keep_href, output text_length,
                  output node_index, output last, input ready);
  modport sink   (input valid, input kind, input value, input node_type, input color,
                  input font_size, input bold, input keep_href, input text_length,
                  input node_index, input last, output ready);
endinterface

interface mtst_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mtst_pkg::CFG_IDX_W-1:0]   idx;
  logic [mtst_pkg::COLOR_W-1:0]     wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

[design/markup_tag_stream_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// markup_tag_stream_tokenizer_unit: byte-stream tokenizer for a small markup
// Turns document bytes into href, node and title records.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake       | word
//  ---------+-----+-----------------+------------------------------------------
//  in_ch    | in  | valid / ready   | in_byte, end_of_doc
//  out_ch   | out | valid / ready   | one record: kind .. last
//  cfg_ch   | in  | valid / ready   | idx (0 text colour, 1 link colour), wdata
//
//  One document byte a cycle. A byte lands in an input register, then parser
//  logic turns it into 0..3 records, pushed into an 8-word result queue;
//  ready drops only while that queue lacks room for three words.
//  A byte giving more than one record is drained at one record a cycle, so
//  the sustained rate is one byte per cycle while the records keep pace.
//  rst_n is synchronous, active low; it resets parser state, queue and colours.
//  cfg_ch is always ready.
//
`default_nettype none

module markup_tag_stream_tokenizer_unit #(
  parameter int MAX_NODES    = 64,
  parameter int URL_MAX      = 128,
  parameter int TEXT_MAX     = 127,
  parameter int TAG_NAME_MAX = 31
) (
  input  wire          clk,
  input  wire          rst_n,
  mtst_in_if.sink      in_ch,
  mtst_out_if.source   out_ch,
  mtst_cfg_if.sink     cfg_ch
);

  // widths of the parser counters
  localparam int TC_MAX = (TEXT_MAX > mtst_pkg::TITLE_MAX) ? TEXT_MAX : mtst_pkg::TITLE_MAX;
  localparam int NC_W   = $clog2(MAX_NODES + 1);
  localparam int TC_W   = $clog2(TC_MAX + 1);
  localparam int TL_W   = $clog2(TAG_NAME_MAX + 1);
  localparam int HL_W   = $clog2(URL_MAX);

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // parser modes
  typedef enum logic [6:0] {
    M_TOP   = 7'b0000001,
    M_NAME  = 7'b0000010,
    M_ATTR  = 7'b0000100,
    M_HREF  = 7'b0001000,
    M_TEXT  = 7'b0010000,
    M_TITLE = 7'b0100000,
    M_SKIP  = 7'b1000000
  } mode_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [mtst_pkg::COLOR_W-1:0] text_color_r;
  logic [mtst_pkg::COLOR_W-1:0] link_color_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= mtst_pkg::TEXT_COLOR_RST;
      link_color_r <= mtst_pkg::LINK_COLOR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        mtst_pkg::REG_TEXT_COLOR: text_color_r <= cfg_ch.wdata;
        mtst_pkg::REG_LINK_COLOR: link_color_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eod_r;
  logic       step_go;
  logic [CNT_W-1:0] count_r;

  // a byte is parsed once the queue has room for its worst case of three words
  assign step_go     = in_vld_r && (count_r <= CNT_W'(FIFO_DEPTH - 3));
  assign in_ch.ready = !in_vld_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (step_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
      in_eod_r  <= in_ch.end_of_doc;
    end
  end

  // --------------------------------------------------------------------------
  // parser state
  // --------------------------------------------------------------------------
  mode_t                mode_r,     mode_nxt;
  logic [4:0][7:0]      tag_pfx_r,  tag_pfx_nxt;
  logic [TL_W-1:0]      tag_len_r,  tag_len_nxt;
  logic [2:0]           href_pos_r, href_pos_nxt;
  logic [HL_W-1:0]      href_len_r, href_len_nxt;
  logic [TC_W-1:0]      txt_cnt_r,  txt_cnt_nxt;
  logic [NC_W-1:0]      node_cnt_r, node_cnt_nxt;
  logic                 href_seen_r, href_seen_nxt;

  mtst_pkg::rec_t       push_rec [3];
  logic [1:0]           push_cnt;

  // working flags of the parser step
  logic       fin;       // tag complete, classify it
  logic       do_attr;   // byte handed on to the attribute scanner
  logic       live;      // node limit not yet reached
  logic       two;
  logic [7:0] b;

  always_comb begin
    mode_nxt      = mode_r;
    tag_pfx_nxt   = tag_pfx_r;
    tag_len_nxt   = tag_len_r;
    href_pos_nxt  = href_pos_r;
    href_len_nxt  = href_len_r;
    txt_cnt_nxt   = txt_cnt_r;
    node_cnt_nxt  = node_cnt_r;
    href_seen_nxt = href_seen_r;
    push_rec[0]   = '0;
    push_rec[1]   = '0;
    push_rec[2]   = '0;
    push_cnt      = 2'd0;
    fin           = 1'b0;
    do_attr       = 1'b0;
    two           = 1'b0;
    b             = in_byte_r;
    live          = node_cnt_r < NC_W'(MAX_NODES);

    // ---- per-mode handling of the byte ----
    if (live) begin
      case (mode_r)
        M_TOP: begin
          if (b == mtst_pkg::CH_LT) begin
            mode_nxt      = M_NAME;
            tag_pfx_nxt   = '0;
            tag_len_nxt   = '0;
            href_pos_nxt  = 3'd0;
            href_seen_nxt = 1'b0;
          end else if (b != mtst_pkg::CH_SPACE && b != mtst_pkg::CH_LF &&
                       b != mtst_pkg::CH_CR && b != mtst_pkg::CH_TAB) begin
            // bare text opens a plain text node
            push_rec[push_cnt] = mtst_pkg::mk_start(mtst_pkg::NT_TEXT, text_color_r,
                                   mtst_pkg::FS_BODY, 1'b0, 1'b0, 6'(node_cnt_nxt));
            push_cnt           = push_cnt + 2'd1;
            push_rec[push_cnt] = mtst_pkg::mk_byte(mtst_pkg::K_TEXT_BYTE, b);
            push_cnt           = push_cnt + 2'd1;
            mode_nxt           = M_TEXT;
            txt_cnt_nxt        = TC_W'(1);
            if (txt_cnt_nxt >= TC_W'(TEXT_MAX)) begin
              push_rec[push_cnt] = mtst_pkg::mk_end(7'(txt_cnt_nxt), 6'(node_cnt_nxt));
              push_cnt           = push_cnt + 2'd1;
              node_cnt_nxt       = node_cnt_nxt + NC_W'(1);
              txt_cnt_nxt        = '0;
              mode_nxt           = M_TOP;
            end
          end
        end
        M_TEXT: begin
          if (b == mtst_pkg::CH_LT) begin
            push_rec[push_cnt] = mtst_pkg::mk_end(7'(txt_cnt_nxt), 6'(node_cnt_nxt));
            push_cnt           = push_cnt + 2'd1;
            node_cnt_nxt       = node_cnt_nxt + NC_W'(1);
            txt_cnt_nxt        = '0;
            mode_nxt           = M_TOP;
            if (node_cnt_nxt < NC_W'(MAX_NODES)) begin
              mode_nxt      = M_NAME;
              tag_pfx_nxt   = '0;
              tag_len_nxt   = '0;
              href_pos_nxt  = 3'd0;
              href_seen_nxt = 1'b0;
            end
          end else begin
            push_rec[push_cnt] = mtst_pkg::mk_byte(mtst_pkg::K_TEXT_BYTE, b);
            push_cnt           = push_cnt + 2'd1;
            txt_cnt_nxt        = txt_cnt_nxt + TC_W'(1);
            // node full: close it, further text opens a fresh plain node
            if (txt_cnt_nxt >= TC_W'(TEXT_MAX)) begin
              push_rec[push_cnt] = mtst_pkg::mk_end(7'(txt_cnt_nxt), 6'(node_cnt_nxt));
              push_cnt           = push_cnt + 2'd1;
              node_cnt_nxt       = node_cnt_nxt + NC_W'(1);
              txt_cnt_nxt        = '0;
              mode_nxt           = M_TOP;
            end
          end
        end
        M_NAME: begin
          if (b == mtst_pkg::CH_GT) begin
            fin = 1'b1;
          end else if (tag_len_r == '0 && b == mtst_pkg::CH_SLASH) begin
            mode_nxt = M_SKIP;   // closing tag
          end else if (b != mtst_pkg::CH_SPACE && tag_len_r < TL_W'(TAG_NAME_MAX)) begin
            if (tag_len_r < TL_W'(mtst_pkg::PFX_LEN)) begin
              tag_pfx_nxt[tag_len_r[2:0]] = b;
            end
            tag_len_nxt = tag_len_r + TL_W'(1);
          end else begin
            mode_nxt     = M_ATTR;
            href_pos_nxt = 3'd0;
            do_attr      = 1'b1;
          end
        end
        M_ATTR: begin
          do_attr = 1'b1;
        end
        M_HREF: begin
          if (b == mtst_pkg::CH_QUOTE) begin
            mode_nxt     = M_ATTR;
            href_pos_nxt = 3'd0;
          end else if (href_len_r < HL_W'(URL_MAX - 1)) begin
            push_rec[push_cnt] = mtst_pkg::mk_byte(mtst_pkg::K_HREF_BYTE, b);
            push_cnt           = push_cnt + 2'd1;
            href_len_nxt       = href_len_r + HL_W'(1);
          end else begin
            mode_nxt     = M_ATTR;
            href_pos_nxt = 3'd0;
            do_attr      = 1'b1;
          end
        end
        M_TITLE: begin
          if (b == mtst_pkg::CH_LT) begin
            mode_nxt = M_SKIP;
          end else begin
            push_rec[push_cnt] = mtst_pkg::mk_byte(mtst_pkg::K_TITLE_BYTE, b);
            push_cnt           = push_cnt + 2'd1;
            txt_cnt_nxt        = txt_cnt_r + TC_W'(1);
            if (txt_cnt_nxt >= TC_W'(mtst_pkg::TITLE_MAX)) begin
              mode_nxt = M_SKIP;
            end
          end
        end
        M_SKIP: begin
          if (b == mtst_pkg::CH_GT) begin
            mode_nxt = M_TOP;
          end
        end
        default: begin
          mode_nxt = M_TOP;
        end
      endcase
    end

    // ---- attribute scanner: looks for href=" ----
    if (do_attr) begin
      if (b == mtst_pkg::CH_GT) begin
        fin = 1'b1;
      end else if (href_pos_nxt < 3'(mtst_pkg::HREF_LEN) &&
                   b == mtst_pkg::href_char(href_pos_nxt)) begin
        href_pos_nxt = href_pos_nxt + 3'd1;
        if (href_pos_nxt >= 3'(mtst_pkg::HREF_LEN)) begin
          push_rec[push_cnt] = mtst_pkg::mk_kind(mtst_pkg::K_HREF_START);
          push_cnt           = push_cnt + 2'd1;
          mode_nxt           = M_HREF;
          href_len_nxt       = '0;
          href_seen_nxt      = 1'b1;
          href_pos_nxt       = 3'd0;
        end
      end else begin
        href_pos_nxt = (b == mtst_pkg::CH_H) ? 3'd1 : 3'd0;
      end
    end

    // an unfinished tag at end of document is closed as if by '>'
    if (in_eod_r && node_cnt_nxt < NC_W'(MAX_NODES) &&
        (mode_nxt == M_NAME || mode_nxt == M_ATTR || mode_nxt == M_HREF)) begin
      fin = 1'b1;
    end

    // ---- tag classification ----
    if (fin) begin
      two = tag_len_nxt >= TL_W'(2);
      if (two && tag_pfx_nxt[0] == mtst_pkg::CH_H && tag_pfx_nxt[1] == mtst_pkg::CH_ONE) begin
        push_rec[push_cnt] = mtst_pkg::mk_start(mtst_pkg::NT_H1, text_color_r,
                               mtst_pkg::FS_H1, 1'b1, 1'b0, 6'(node_cnt_nxt));
        push_cnt    = push_cnt + 2'd1;
        mode_nxt    = M_TEXT;
        txt_cnt_nxt = '0;
      end else if (two && tag_pfx_nxt[0] == mtst_pkg::CH_H &&
                   tag_pfx_nxt[1] == mtst_pkg::CH_TWO) begin
        push_rec[push_cnt] = mtst_pkg::mk_start(mtst_pkg::NT_H2, text_color_r,
                               mtst_pkg::FS_H2, 1'b1, 1'b0, 6'(node_cnt_nxt));
        push_cnt    = push_cnt + 2'd1;
        mode_nxt    = M_TEXT;
        txt_cnt_nxt = '0;
      end else if (two && tag_pfx_nxt[0] == mtst_pkg::CH_H &&
                   tag_pfx_nxt[1] == mtst_pkg::CH_THREE) begin
        push_rec[push_cnt] = mtst_pkg::mk_start(mtst_pkg::NT_H3, text_color_r,
                               mtst_pkg::FS_H3, 1'b1, 1'b0, 6'(node_cnt_nxt));
        push_cnt    = push_cnt + 2'd1;
        mode_nxt    = M_TEXT;
        txt_cnt_nxt = '0;
      end else if (tag_len_nxt == TL_W'(1) && tag_pfx_nxt[0] == mtst_pkg::CH_P) begin
        push_rec[push_cnt] = mtst_pkg::mk_start(mtst_pkg::NT_PARA, text_color_r,
                               mtst_pkg::FS_BODY, 1'b0, 1'b0, 6'(node_cnt_nxt));
        push_cnt    = push_cnt + 2'd1;
        mode_nxt    = M_TEXT;
        txt_cnt_nxt = '0;
      end else if (tag_len_nxt == TL_W'(1) && tag_pfx_nxt[0] == mtst_pkg::CH_A) begin
        push_rec[push_cnt] = mtst_pkg::mk_start(mtst_pkg::NT_ANCHOR, link_color_r,
                               mtst_pkg::FS_BODY, 1'b0, href_seen_nxt, 6'(node_cnt_nxt));
        push_cnt    = push_cnt + 2'd1;
        mode_nxt    = M_TEXT;
        txt_cnt_nxt = '0;
      end else if (two && tag_pfx_nxt[0] == mtst_pkg::CH_B &&
                   tag_pfx_nxt[1] == mtst_pkg::CH_R) begin
        // line break: a node with no text, opened and closed at once
        push_rec[push_cnt] = mtst_pkg::mk_start(mtst_pkg::NT_BREAK, text_color_r,
                               mtst_pkg::FS_BODY, 1'b0, 1'b0, 6'(node_cnt_nxt));
        push_cnt           = push_cnt + 2'd1;
        push_rec[push_cnt] = mtst_pkg::mk_end(7'd0, 6'(node_cnt_nxt));
        push_cnt           = push_cnt + 2'd1;
        node_cnt_nxt       = node_cnt_nxt + NC_W'(1);
        txt_cnt_nxt        = '0;
        mode_nxt           = M_TOP;
      end else if (tag_len_nxt >= TL_W'(mtst_pkg::PFX_LEN) &&
                   tag_pfx_nxt[0] == mtst_pkg::CH_T && tag_pfx_nxt[1] == mtst_pkg::CH_I &&
                   tag_pfx_nxt[2] == mtst_pkg::CH_T && tag_pfx_nxt[3] == mtst_pkg::CH_L &&
                   tag_pfx_nxt[4] == mtst_pkg::CH_E) begin
        push_rec[push_cnt] = mtst_pkg::mk_kind(mtst_pkg::K_TITLE_START);
        push_cnt           = push_cnt + 2'd1;
        mode_nxt           = M_TITLE;
        txt_cnt_nxt        = '0;
      end else begin
        mode_nxt = M_TOP;   // unknown tag, dropped
      end
    end

    // ---- end of document: close open node, then start over ----
    if (in_eod_r) begin
      if (node_cnt_nxt < NC_W'(MAX_NODES) && mode_nxt == M_TEXT) begin
        push_rec[push_cnt] = mtst_pkg::mk_end(7'(txt_cnt_nxt), 6'(node_cnt_nxt));
        push_cnt           = push_cnt + 2'd1;
      end
      mode_nxt      = M_TOP;
      tag_pfx_nxt   = '0;
      tag_len_nxt   = '0;
      href_pos_nxt  = 3'd0;
      href_len_nxt  = '0;
      txt_cnt_nxt   = '0;
      node_cnt_nxt  = '0;
      href_seen_nxt = 1'b0;
    end

    // mark the final record of this byte
    if (push_cnt != 2'd0) begin
      push_rec[push_cnt - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_TOP;
      tag_pfx_r   <= '0;
      tag_len_r   <= '0;
      href_pos_r  <= 3'd0;
      href_len_r  <= '0;
      txt_cnt_r   <= '0;
      node_cnt_r  <= '0;
      href_seen_r <= 1'b0;
    end else if (step_go) begin
      mode_r      <= mode_nxt;
      tag_pfx_r   <= tag_pfx_nxt;
      tag_len_r   <= tag_len_nxt;
      href_pos_r  <= href_pos_nxt;
      href_len_r  <= href_len_nxt;
      txt_cnt_r   <= txt_cnt_nxt;
      node_cnt_r  <= node_cnt_nxt;
      href_seen_r <= href_seen_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result queue: up to three words in; while out_ch is ready, one word out per cycle
  // --------------------------------------------------------------------------
  mtst_pkg::rec_t     fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   push_n;
  logic               pop;
  mtst_pkg::rec_t     head;

  assign push_n = step_go ? CNT_W'(push_cnt) : '0;
  assign pop    = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (step_go) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < push_cnt) begin
          fifo_r[wr_ptr_r + PTR_W'(i)] <= push_rec[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_r + push_n - CNT_W'(pop);
    end
  end

  assign head               = fifo_r[rd_ptr_r];
  assign out_ch.valid       = count_r != '0;
  assign out_ch.kind        = head.kind;
  assign out_ch.value       = head.value;
  assign out_ch.node_type   = head.node_type;
  assign out_ch.color       = head.color;
  assign out_ch.font_size   = head.font_size;
  assign out_ch.bold        = head.bold;
  assign out_ch.keep_href   = head.keep_href;
  assign out_ch.text_length = head.text_length;
  assign out_ch.node_index  = head.node_index;
  assign out_ch.last        = head.last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_eod_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && in_eod_r |=> mode_r == M_TOP && node_cnt_r == '0 && tag_len_r == '0)
    else $error("parser not restarted after end of document");

  a_text_bound: assert property (@(posedge clk) disable iff (!rst_n)
    txt_cnt_r <= TC_W'(TC_MAX))
    else $error("text count beyond limit");

endmodule

`default_nettype wire
